@@ design/deq_pkg.sv @@
package deq_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int VALUE_W       = 64;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    // operation and push_value, padded to whole bytes.
    localparam int IN_W          = ((OP_W + VALUE_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_COUNT      = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell of one chain.
    typedef struct packed {
        logic                      shift_in;   // insert at cell 0, all cells move up
        logic                      shift_out;  // drop cell 0, all cells move down
        logic                      append;     // write the cell just past the last one
        logic signed [VALUE_W-1:0] value;
    } chain_cmd_t;

endpackage

@@ design/deq_cell.sv @@
module deq_cell
    import deq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 11
)
(
    input  logic                      clk,
    input  chain_cmd_t                cmd,
    input  logic [CW-1:0]             count,
    input  logic signed [VALUE_W-1:0] left_data,
    input  logic signed [VALUE_W-1:0] right_data,
    output logic signed [VALUE_W-1:0] data
);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.shift_in)
        begin
            data_next = left_data;
        end
        else if (cmd.shift_out)
        begin
            data_next = right_data;
        end
        else if (cmd.append && (count == CW'(INDEX)))
        begin
            data_next = cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ design/deq_chain.sv @@
module deq_chain
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                      clk,
    input  chain_cmd_t                cmd,
    input  logic [CW-1:0]             count,
    output logic signed [VALUE_W-1:0] head
);

    logic signed [VALUE_W-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_data;
        logic signed [VALUE_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = cmd.value;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        // The last cell has nothing above it and keeps its value on a shift out.
        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        deq_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

@@ design/double_ended_queue.sv @@
// Channel   Direction  Transaction                    Payload (lowest bit first)
// s_axis    in         one request                    operation, push_value
// m_axis    out        one result for each request    status, data_value, entry_count
//
// Each accepted request has its result written into the output register at the edge
// that accepts it; a new request is accepted in every cycle while the result is
// taken or the output register is empty. Two rows of DEPTH cells hold the queue,
// one in order from the front and one from the back, so both ends sit in cell 0;
// a pop shifts one row down, a push shifts one row up and appends to the other.
// Reset empties the queue and the output register at once; no clearing pass.
// A stall on m_axis holds the result and stops accepting requests.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter  int DEPTH = DEPTH_DEFAULT,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int OUT_W = ((STATUS_W + VALUE_W + CW + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // operation, push_value, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, data_value, entry_count, zero pad
);

    logic                      accept;
    op_t                       op;
    logic signed [VALUE_W-1:0] push_value;
    logic                      empty;
    logic                      full;
    logic signed [VALUE_W-1:0] front_head;
    logic signed [VALUE_W-1:0] back_head;
    chain_cmd_t                front_cmd;
    chain_cmd_t                back_cmd;
    status_t                   status;
    logic signed [VALUE_W-1:0] data_value;

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      valid_reg;
    logic                      valid_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;
    logic [CW-1:0]             result_count_reg;
    logic [CW-1:0]             result_count_next;

    assign s_tready   = !valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign op         = op_t'(s_tdata[OP_W-1:0]);
    assign push_value = s_tdata[OP_W+VALUE_W-1:OP_W];
    assign empty      = (count_reg == '0);
    assign full       = (count_reg == CW'(DEPTH));

    always_comb
    begin
        front_cmd       = '0;
        back_cmd        = '0;
        front_cmd.value = push_value;
        back_cmd.value  = push_value;
        status          = ST_OK;
        data_value      = '0;
        count_next      = count_reg;
        case (op)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    front_cmd.shift_in = accept;
                    back_cmd.append    = accept;
                    count_next         = count_reg + 1'b1;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    back_cmd.shift_in = accept;
                    front_cmd.append  = accept;
                    count_next        = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    data_value = front_head;
                    if (op == OP_POP_FRONT)
                    begin
                        // The back row loses its last occupied cell through the count.
                        front_cmd.shift_out = accept;
                        count_next          = count_reg - 1'b1;
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    data_value = back_head;
                    if (op == OP_POP_BACK)
                    begin
                        back_cmd.shift_out = accept;
                        count_next         = count_reg - 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    deq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_front_chain (
        .clk   (clk),
        .cmd   (front_cmd),
        .count (count_reg),
        .head  (front_head)
    );

    deq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_back_chain (
        .clk   (clk),
        .cmd   (back_cmd),
        .count (count_reg),
        .head  (back_head)
    );

    always_comb
    begin
        valid_next        = valid_reg;
        status_next       = status_reg;
        data_next         = data_reg;
        result_count_next = result_count_reg;
        if (accept)
        begin
            valid_next        = 1'b1;
            status_next       = status;
            data_next         = data_value;
            result_count_next = count_next;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        data_reg         <= data_next;
        result_count_reg <= result_count_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_W'({result_count_reg, data_reg, status_reg});

endmodule
